// File: hdl/pcgbg_pkg.sv
// ----------------------------------------------------------------------------
// pcgbg_pkg
// Shared constants and types for the PCG64 DXSM bounded generator.
// ----------------------------------------------------------------------------
package pcgbg_pkg;

    localparam logic [63:0] MUL_HI   = 64'd2549297995355413924;
    localparam logic [63:0] MUL_LO   = 64'd4865540595714422341;
    localparam logic [63:0] INC_HI   = 64'd6364136223846793005;
    localparam logic [63:0] INC_LO   = 64'd1442695040888963407;
    localparam logic [63:0] DXSM_MUL = 64'hda942042e4dd58b5;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_RAW    = 2'd0;
    localparam logic [1:0] OP_BELOW  = 2'd1;
    localparam logic [1:0] OP_RESEED = 2'd2;

    localparam logic [7:0] REG_SEED_HIGH = 8'd0;
    localparam logic [7:0] REG_SEED_LOW  = 8'd1;

    typedef enum logic [2:0] {
        K_ZERO,
        K_RAW,
        K_POW2,
        K_LEMIRE,
        K_RESEED
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [63:0] bound;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV1,
        S_ADV2,
        S_ADV3,
        S_ADV4,
        S_DX1,
        S_DX2,
        S_DX3,
        S_LEM,
        S_REM,
        S_CHECK
    } seq_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

endpackage

// File: hdl/pcgbg_front.sv
// ----------------------------------------------------------------------------
// pcgbg_front
// Accepts requests and sorts them into command kinds for the sequencer.
// ----------------------------------------------------------------------------
module pcgbg_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,   // op
    input  logic [63:0]       s_tdata,   // bound
    input  logic              q_full,
    output logic              q_push,
    output pcgbg_pkg::cmd_t   q_cmd
);
    import pcgbg_pkg::*;

    logic [63:0] bound_m1;
    logic        is_pow2;

    assign bound_m1 = s_tdata - 64'd1;
    assign is_pow2  = (s_tdata & bound_m1) == 64'd0;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cmd.bound = s_tdata;
        case (s_tuser)
            OP_RAW:    q_cmd.kind = K_RAW;
            OP_BELOW: begin
                if (s_tdata == 64'd0) q_cmd.kind = K_ZERO;
                else if (is_pow2)     q_cmd.kind = K_POW2;
                else                  q_cmd.kind = K_LEMIRE;
            end
            OP_RESEED: q_cmd.kind = K_RESEED;
            default:   q_cmd.kind = K_ZERO;
        endcase
    end

endmodule

// File: hdl/pcgbg_fifo.sv
// ----------------------------------------------------------------------------
// pcgbg_fifo
// Small command queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module pcgbg_fifo #(
    parameter int DEPTH = pcgbg_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pcgbg_pkg::cmd_t push_cmd,
    input  logic            pop,
    output pcgbg_pkg::cmd_t pop_cmd,
    output logic            full,
    output logic            empty
);
    import pcgbg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: hdl/pcgbg_mul.sv
// ----------------------------------------------------------------------------
// pcgbg_mul
// 64x64 -> 128 multiplier built on one 32x32 multiplier that forms the four partial products in turn.
// ----------------------------------------------------------------------------
module pcgbg_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcgbg_pkg::mul_req_t req,
    output pcgbg_pkg::mul_rsp_t rsp
);
    import pcgbg_pkg::*;

    logic [63:0]  a_reg, b_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;

    logic [31:0]  op_a, op_b;
    logic [63:0]  mult;
    logic [1:0]   prev_idx;
    logic [127:0] pp_ext;

    always_comb begin
        op_a = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        op_b = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    end

    assign mult     = op_a * op_b;
    assign prev_idx = 2'(cnt_reg - 3'd1);

    always_comb begin
        case (prev_idx)
            2'd0:    pp_ext = {64'd0, pp_reg};
            2'd1,
            2'd2:    pp_ext = {32'd0, pp_reg, 32'd0};
            default: pp_ext = {pp_reg, 64'd0};
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (cnt_reg != 3'd4) pp_reg  <= mult;
                if (cnt_reg != 3'd0) acc_reg <= acc_reg + pp_ext;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("multiplier done held longer than one cycle");
    a_done_after_four: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == 3'd4 && !req.start) |=> done_reg && !busy_reg)
        else $error("multiplier did not finish on its last step");

endmodule

// File: hdl/pcgbg_back.sv
// ----------------------------------------------------------------------------
// pcgbg_back
// Sequencer: LCG advance, DXSM output, masking, Lemire rejection, remainder, reseed and zero results.
// ----------------------------------------------------------------------------
module pcgbg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  pcgbg_pkg::cmd_t     q_cmd,
    output logic                q_pop,
    input  logic [63:0]         seed_high,
    input  logic [63:0]         seed_low,
    output pcgbg_pkg::mul_req_t mreq,
    input  pcgbg_pkg::mul_rsp_t mrsp,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         out_value
);
    import pcgbg_pkg::*;

    seq_state_t  state_reg, state_next;
    cmd_kind_t   kind_reg, kind_next;
    logic [63:0] bound_reg, bound_next;
    logic [63:0] lcg_hi_reg, lcg_hi_next, lcg_lo_reg, lcg_lo_next;
    logic [63:0] t_hi_reg, t_hi_next, t_lo_reg, t_lo_next;
    logic [63:0] lim_reg, lim_next;
    logic        lim_ok_reg, lim_ok_next;
    logic [63:0] rem_reg, rem_next, num_reg, num_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] value_reg, value_next;

    logic [127:0] adv_sum;
    logic [64:0]  rem_sh;
    logic [63:0]  xs, draw;

    assign adv_sum   = {t_hi_reg, t_lo_reg} + {INC_HI, INC_LO};
    assign rem_sh    = {rem_reg, num_reg[63]};
    assign xs        = mrsp.prod[63:0] ^ (mrsp.prod[63:0] >> 48);
    assign draw      = mrsp.prod[63:0];
    assign out_valid = out_valid_reg;
    assign out_value = value_reg;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        bound_next     = bound_reg;
        lcg_hi_next    = lcg_hi_reg;
        lcg_lo_next    = lcg_lo_reg;
        t_hi_next      = t_hi_reg;
        t_lo_next      = t_lo_reg;
        lim_next       = lim_reg;
        lim_ok_next    = lim_ok_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        q_pop          = 1'b0;
        mreq.start     = 1'b0;
        mreq.a         = lcg_lo_reg;
        mreq.b         = MUL_LO;

        if (out_valid_reg && out_ready) out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (!q_empty && !out_valid_reg) begin
                    q_pop       = 1'b1;
                    kind_next   = q_cmd.kind;
                    bound_next  = q_cmd.bound;
                    lim_ok_next = 1'b0;
                    case (q_cmd.kind)
                        K_ZERO: begin
                            out_valid_next = 1'b1;
                            value_next     = '0;
                        end
                        K_RESEED: begin
                            lcg_hi_next    = seed_high;
                            lcg_lo_next    = seed_low;
                            out_valid_next = 1'b1;
                            value_next     = '0;
                        end
                        default: begin
                            mreq.start = 1'b1;
                            state_next = S_ADV1;
                        end
                    endcase
                end
            end
            S_ADV1: begin
                if (mrsp.done) begin
                    t_hi_next  = mrsp.prod[127:64];
                    t_lo_next  = mrsp.prod[63:0];
                    mreq.start = 1'b1;
                    mreq.a     = lcg_hi_reg;
                    state_next = S_ADV2;
                end
            end
            S_ADV2: begin
                if (mrsp.done) begin
                    t_hi_next  = t_hi_reg + mrsp.prod[63:0];
                    mreq.start = 1'b1;
                    mreq.b     = MUL_HI;
                    state_next = S_ADV3;
                end
            end
            S_ADV3: begin
                if (mrsp.done) begin
                    t_hi_next  = t_hi_reg + mrsp.prod[63:0];
                    state_next = S_ADV4;
                end
            end
            S_ADV4: begin
                lcg_hi_next = adv_sum[127:64];
                lcg_lo_next = adv_sum[63:0];
                state_next  = S_DX1;
            end
            S_DX1: begin
                mreq.start = 1'b1;
                mreq.a     = lcg_hi_reg ^ (lcg_hi_reg >> 32);
                mreq.b     = DXSM_MUL;
                state_next = S_DX2;
            end
            S_DX2: begin
                if (mrsp.done) begin
                    mreq.start = 1'b1;
                    mreq.a     = xs;
                    mreq.b     = lcg_lo_reg | 64'd1;
                    state_next = S_DX3;
                end
            end
            S_DX3: begin
                if (mrsp.done) begin
                    case (kind_reg)
                        K_LEMIRE: begin
                            mreq.start = 1'b1;
                            mreq.a     = draw;
                            mreq.b     = bound_reg;
                            state_next = S_LEM;
                        end
                        K_POW2: begin
                            out_valid_next = 1'b1;
                            value_next     = draw & (bound_reg - 64'd1);
                            state_next     = S_IDLE;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            value_next     = draw;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
            end
            S_LEM: begin
                if (mrsp.done) begin
                    t_hi_next = mrsp.prod[127:64];
                    t_lo_next = mrsp.prod[63:0];
                    if (mrsp.prod[63:0] >= bound_reg ||
                        (lim_ok_reg && mrsp.prod[63:0] >= lim_reg)) begin
                        out_valid_next = 1'b1;
                        value_next     = mrsp.prod[127:64];
                        state_next     = S_IDLE;
                    end else if (lim_ok_reg) begin
                        // rejected: draw again
                        mreq.start = 1'b1;
                        state_next = S_ADV1;
                    end else begin
                        // threshold (2^64 - bound) mod bound, one bit a cycle
                        num_next   = 64'd0 - bound_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = S_REM;
                    end
                end
            end
            S_REM: begin
                if (rem_sh >= {1'b0, bound_reg})
                    rem_next = 64'(rem_sh - {1'b0, bound_reg});
                else
                    rem_next = rem_sh[63:0];
                num_next = num_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    lim_next    = rem_next;
                    lim_ok_next = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (t_lo_reg < lim_reg) begin
                    mreq.start = 1'b1;
                    state_next = S_ADV1;
                end else begin
                    out_valid_next = 1'b1;
                    value_next     = t_hi_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            lim_ok_reg    <= 1'b0;
            lcg_hi_reg    <= '0;
            lcg_lo_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lim_ok_reg    <= lim_ok_next;
            lcg_hi_reg    <= lcg_hi_next;
            lcg_lo_reg    <= lcg_lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        bound_reg <= bound_next;
        t_hi_reg  <= t_hi_next;
        t_lo_reg  <= t_lo_next;
        lim_reg   <= lim_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        cnt_reg   <= cnt_next;
        value_reg <= value_next;
    end

    a_pop_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !out_valid_reg && state_reg == S_IDLE)
        else $error("command taken while a result is pending");
    a_rem_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_REM |-> !lim_ok_reg)
        else $error("threshold recomputed within one request");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(value_reg))
        else $error("pending result changed before transfer");

endmodule

// File: hdl/pcg64_dxsm_bounded_generator_unit.sv
// ----------------------------------------------------------------------------
// pcg64_dxsm_bounded_generator_unit
// PCG64 DXSM generator with raw, bounded and reseed requests.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the op (0 raw draw,
// 1 draw below s_tdata, 2 reseed, 3 returns zero) and s_tdata the bound.
// Each request gives exactly one result transfer on the m_ stream.
// Seeds are written on the cfg_ channel (index 0 high word, 1 low word);
// the user must write them only while the unit is idle, as the unit does
// not enforce it. cfg_ready is always high. Zero-bound, op 3 and reseed
// requests need no multiplier. A raw draw takes five products of the
// shared 32x32 multiplier plus a state update; masking costs nothing
// extra. A general bound adds one product per attempt and, on the first
// near-rejection, the bit-serial remainder and check; each rejected
// attempt runs the advance, DXSM and bound products again. One request is
// worked at a time; the next is taken once the last result has transferred.
// A two-entry queue keeps taking requests while the sequencer is busy or
// a result waits for m_tready; once it is full, s_tready drops.
// Reset clears the generator state and seeds to zero and empties the queue.
// ----------------------------------------------------------------------------
module pcg64_dxsm_bounded_generator_unit #(
    parameter int QUEUE_DEPTH = pcgbg_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // [1:0] op
    input  logic [63:0] s_tdata,    // [63:0] bound
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import pcgbg_pkg::*;

    logic [63:0] seed_high_reg, seed_low_reg;
    logic        q_push, q_pop, q_full, q_empty;
    cmd_t        push_cmd, pop_cmd;
    mul_req_t    mreq;
    mul_rsp_t    mrsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_high_reg <= '0;
            seed_low_reg  <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SEED_HIGH) seed_high_reg <= cfg_data;
            if (cfg_index == REG_SEED_LOW)  seed_low_reg  <= cfg_data;
        end
    end

    pcgbg_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    pcgbg_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    pcgbg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    pcgbg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .seed_high (seed_high_reg),
        .seed_low  (seed_low_reg),
        .mreq      (mreq),
        .mrsp      (mrsp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata)
    );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCG64 DXSM bounded generator unit.
// ----------------------------------------------------------------------------
// Requests are queued by a stimulus process and sent by a bursty driver. A
// local generator model predicts every result on acceptance, and the monitor
// compares each result transfer against the oldest prediction. Seeds are
// rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import pcgbg_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] bound;
    } req_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;

    req_t        pending_reqs[$];
    logic [63:0] expected_values[$];
    logic [63:0] mdl_seed_hi, mdl_seed_lo;
    logic [127:0] mdl_state;
    int          error_count;
    int          gap_left, burst_left;
    int          hold_cycles;
    logic        hold_request;
    logic        s_fire;

    pcg64_dxsm_bounded_generator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---- generator model ----
    function automatic logic [63:0] next_raw();
        logic [63:0] h;
        mdl_state = mdl_state * {MUL_HI, MUL_LO} + {INC_HI, INC_LO};
        h = mdl_state[127:64];
        h = h ^ (h >> 32);
        h = h * DXSM_MUL;
        h = h ^ (h >> 48);
        h = h * (mdl_state[63:0] | 64'd1);
        return h;
    endfunction

    function automatic logic [63:0] predict_value(req_t r);
        logic [127:0] prod;
        logic [63:0]  limit;
        case (r.op)
            OP_RAW: return next_raw();
            OP_BELOW: begin
                if (r.bound == 64'd0) return 64'd0;
                if ((r.bound & (r.bound - 64'd1)) == 64'd0)
                    return next_raw() & (r.bound - 64'd1);
                prod = {64'd0, next_raw()} * {64'd0, r.bound};
                if (prod[63:0] < r.bound) begin
                    limit = (64'd0 - r.bound) % r.bound;
                    while (prod[63:0] < limit)
                        prod = {64'd0, next_raw()} * {64'd0, r.bound};
                end
                return prod[127:64];
            end
            OP_RESEED: begin
                mdl_state = {mdl_seed_hi, mdl_seed_lo};
                return 64'd0;
            end
            default: return 64'd0;
        endcase
    endfunction

    // ---- driver ----
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else if (!s_tvalid || s_fire) begin
            // s_fire marks a transfer at the last rising edge
            if (pending_reqs.size() != 0 && gap_left == 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_reqs[0].op;
                s_tdata  <= pending_reqs[0].bound;
                void'(pending_reqs.pop_front());
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // prediction at acceptance
    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_values.push_back(predict_value('{op: s_tuser, bound: s_tdata}));
    end

    // ---- receiver ----
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_request && hold_cycles == 0) begin
            hold_cycles <= 3000;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= (hold_cycles == 1);
        end else begin
            case ($urandom_range(0, 3))
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 7) != 0);
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // ---- monitor ----
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                $error("unexpected result transfer: value %h", m_tdata);
                error_count++;
            end else begin
                if (m_tdata !== expected_values[0]) begin
                    $error("value: expected %h, actual %h", expected_values[0], m_tdata);
                    error_count++;
                end
                void'(expected_values.pop_front());
            end
        end
    end

    // ---- stimulus ----
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] random_bound();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1 << $urandom_range(0, 63);
            2: return 64'd3 << $urandom_range(62, 62);  // huge, rejection-heavy
            3: return 64'(1) + $urandom_range(1, 1000);
            4: return (64'd1 << 63) + 64'($urandom_range(1, 255));
            5: return 64'hffff_ffff_ffff_ffff - $urandom_range(0, 3);
            default: return rand64();
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        case ($urandom_range(0, 19))
            0: r.op = OP_RESEED;
            1: r.op = 2'd3;
            2, 3, 4, 5, 6, 7: r.op = OP_RAW;
            default: r.op = OP_BELOW;
        endcase
        r.bound = (r.op == OP_BELOW) ? random_bound() : rand64();
        return r;
    endfunction

    task automatic write_seed(input logic [7:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SEED_HIGH) mdl_seed_hi = val;
        else mdl_seed_lo = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_values.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        error_count = 0;
        mdl_seed_hi = '0;
        mdl_seed_lo = '0;
        mdl_state = '0;
        hold_request = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero state, extremes, every op and special case
        pending_reqs.push_back('{op: OP_RAW, bound: 64'd0});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'd0});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'd1});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'h8000_0000_0000_0000});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'hffff_ffff_ffff_ffff});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'h8000_0000_0000_0001});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'hc000_0000_0000_0000});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'd3});
        pending_reqs.push_back('{op: 2'd3, bound: 64'hffff_ffff_ffff_ffff});
        pending_reqs.push_back('{op: OP_RESEED, bound: 64'd0});
        pending_reqs.push_back('{op: OP_RAW, bound: 64'hffff_ffff_ffff_ffff});
        drain();

        write_seed(REG_SEED_HIGH, 64'hffff_ffff_ffff_ffff);
        write_seed(REG_SEED_LOW, 64'hffff_ffff_ffff_ffff);
        pending_reqs.push_back('{op: OP_RESEED, bound: 64'd0});
        pending_reqs.push_back('{op: OP_RAW, bound: 64'd0});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'd6});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'h4000_0000_0000_0000});
        pending_reqs.push_back('{op: OP_BELOW, bound: 64'hc000_0000_0000_0001});
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            write_seed(REG_SEED_HIGH, (phase == 1) ? 64'd0 : rand64());
            write_seed(REG_SEED_LOW, (phase == 2) ? 64'd0 : rand64());
            for (int i = 0; i < 240; i++) pending_reqs.push_back(random_req());
            if (phase == 3) begin
                // long receiver hold-off while requests keep coming
                hold_request = 1'b1;
                @(negedge aclk);
                @(negedge aclk);
                hold_request = 1'b0;
            end
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #60000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
